/* hw/rtl/trip_window_fuel_speed_average_macros.svh */
// assertion helpers for the trip window averager
`ifndef TRIP_WINDOW_FUEL_SPEED_AVERAGE_MACROS_SVH
`define TRIP_WINDOW_FUEL_SPEED_AVERAGE_MACROS_SVH

`define TWA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/twa_pkg.sv */
// ----------------------------------------------------------------------------
// twa_pkg
// constants and types shared by the trip window averager
// ----------------------------------------------------------------------------
package twa_pkg;
    localparam int unsigned WINDOW_DEFAULT = 200;
    localparam logic [15:0] FLOOR_RESET = 16'd10;
    localparam logic [40:0] KM_UNITS = 41'd3600000000;
    localparam logic [39:0] MAX40 = {40{1'b1}};
    localparam logic [40:0] MAX41 = {41{1'b1}};
    localparam logic [47:0] MAX48 = {48{1'b1}};
    localparam logic [55:0] MAX56 = {56{1'b1}};
    localparam logic [26:0] FUEL_DIV = 27'd109515000;
    localparam logic [38:0] SPEED_NUM = 39'd360000000000;
    localparam logic [47:0] ONE_SECOND_US = 48'd1000000;
    localparam int unsigned DIV_W = 64;

    typedef struct packed {
        logic [47:0] timestamp_us;
        logic [15:0] airflow_raw;
        logic [7:0]  speed_kmh;
    } in_item_t;

    typedef struct packed {
        logic [15:0] avg_consumption_centi;
        logic [15:0] avg_speed_centi;
        logic [7:0]  window_km;
        logic        km_closed;
    } out_item_t;
endpackage

/* hw/rtl/twa_if.sv */
// ----------------------------------------------------------------------------
// twa_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface twa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/trip_window_fuel_speed_average.sv */
// ----------------------------------------------------------------------------
// trip_window_fuel_speed_average
// per-kilometre ring of fuel and time, window averages of consumption and speed
// ----------------------------------------------------------------------------
//  channel      dir  payload
//  cfg          in   airflow_floor (16 bit)
//  sample       in   timestamp_us, airflow_raw, speed_kmh
//  result       out  avg_consumption_centi, avg_speed_centi, window_km, km_closed
//
//  each sample beat runs two 64-step divisions on one shared divider before
//  the result register is loaded; a kilometre close first adds the ring read,
//  subtract and write-back steps; the next sample beat is taken only in idle
//  ring entries sit in two rams, the old bucket read ahead of the write-back
//  reset clears control and totals, no clearing pass (ring read only once full)
//  a waiting result holds in its output register while the next sample is
//  taken; that sample waits in the output step until the result beat has gone
// ----------------------------------------------------------------------------
`include "trip_window_fuel_speed_average_macros.svh"

module trip_window_fuel_speed_average
    import twa_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    twa_if.sink   cfg,
    twa_if.sink   sample,
    twa_if.source result
);
    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned KW = $clog2(WINDOW + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_SUB   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_DIV1  = 4'd6;
    localparam logic [3:0] S_WAIT1 = 4'd7;
    localparam logic [3:0] S_DIV2  = 4'd8;
    localparam logic [3:0] S_WAIT2 = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]  state_reg;
    logic [15:0] floor_reg;
    logic        primed_reg;
    logic [47:0] last_time_reg;
    logic [40:0] dist_reg;
    logic [47:0] fuel_acc_reg;
    logic [39:0] time_acc_reg;
    logic [55:0] fuel_total_reg;
    logic [47:0] time_total_reg;
    logic [KW-1:0] km_count_reg;
    logic [AW-1:0] head_reg;
    logic        full_reg;
    logic        closed_reg;
    in_item_t    item_reg;
    logic [47:0] dt_reg;
    logic [55:0] dprod_reg;
    logic [63:0] fprod_reg;
    logic [15:0] cons_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic        we;
    logic [47:0] fuel_rd;
    logic [39:0] time_rd;
    logic        div_start;
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic        div_busy;

    twa_ram #(.WIDTH(48), .DEPTH(WINDOW)) u_fuel_ram (
        .clk(clk), .we(we), .addr(head_reg), .wdata(fuel_acc_reg), .rdata(fuel_rd)
    );
    twa_ram #(.WIDTH(40), .DEPTH(WINDOW)) u_time_ram (
        .clk(clk), .we(we), .addr(head_reg), .wdata(time_acc_reg), .rdata(time_rd)
    );
    twa_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    assign we        = (state_reg == S_ADD);
    assign div_start = (state_reg == S_DIV1) || (state_reg == S_DIV2);
    assign cfg.ready    = (state_reg == S_IDLE);
    assign sample.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_comb
    begin
        if (state_reg == S_DIV1)
        begin
            div_a = 64'(fuel_total_reg);
            div_b = 64'(km_count_reg) * 64'(FUEL_DIV);
        end
        else
        begin
            div_a = 64'(km_count_reg) * 64'(SPEED_NUM);
            div_b = 64'(time_total_reg);
        end
    end

    // saturating sums
    logic [41:0] dsum;
    logic [48:0] fsum;
    logic [40:0] tsum;
    logic [56:0] ftsum;
    logic [48:0] ttsum;
    logic [55:0] ft_sub;
    logic [47:0] tt_sub;
    logic [AW-1:0] head_inc;
    always_comb
    begin
        dsum  = {1'b0, dist_reg} + ((dprod_reg > 56'(MAX41)) ? {1'b0, MAX41}
                                                              : 42'(dprod_reg));
        fsum  = {1'b0, fuel_acc_reg} + ((fprod_reg > 64'(MAX48)) ? {1'b0, MAX48}
                                                                  : 49'(fprod_reg));
        tsum  = {1'b0, time_acc_reg} + ((dt_reg > 48'(MAX40)) ? {1'b0, MAX40}
                                                               : 41'(dt_reg));
        ftsum = {1'b0, fuel_total_reg} + 57'(fuel_acc_reg);
        ttsum = {1'b0, time_total_reg} + 49'(time_acc_reg);
        ft_sub = (56'(fuel_rd) > fuel_total_reg) ? '0 : fuel_total_reg - 56'(fuel_rd);
        tt_sub = (48'(time_rd) > time_total_reg) ? '0 : time_total_reg - 48'(time_rd);
        head_inc = (head_reg == AW'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            floor_reg      <= FLOOR_RESET;
            primed_reg     <= 1'b0;
            last_time_reg  <= '0;
            dist_reg       <= '0;
            fuel_acc_reg   <= '0;
            time_acc_reg   <= '0;
            fuel_total_reg <= '0;
            time_total_reg <= '0;
            km_count_reg   <= '0;
            head_reg       <= '0;
            full_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // in the output step a new beat may replace the one leaving
            if (result.valid && result.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg.valid)
                    begin
                        floor_reg <= cfg.data;
                    end
                    if (sample.valid && sample.ready)
                    begin
                        item_reg   <= sample.data;
                        closed_reg <= 1'b0;
                        if (!primed_reg)
                        begin
                            primed_reg    <= 1'b1;
                            last_time_reg <= sample.data.timestamp_us;
                            state_reg     <= S_DIV1;
                        end
                        else
                        begin
                            dt_reg        <= sample.data.timestamp_us - last_time_reg;
                            last_time_reg <= sample.data.timestamp_us;
                            state_reg     <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    dprod_reg <= 56'(item_reg.speed_kmh) * 56'(dt_reg);
                    fprod_reg <= (item_reg.airflow_raw > floor_reg)
                                 ? 64'(item_reg.airflow_raw) * 64'(dt_reg) : '0;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    dist_reg     <= dsum[41] ? MAX41 : dsum[40:0];
                    fuel_acc_reg <= fsum[48] ? MAX48 : fsum[47:0];
                    time_acc_reg <= tsum[40] ? MAX40 : tsum[39:0];
                    if ((dsum[41] ? MAX41 : dsum[40:0]) >= KM_UNITS)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_DIV1;
                    end
                end
                S_RD:
                begin
                    // ram read of the old bucket at head
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    if (full_reg)
                    begin
                        fuel_total_reg <= ft_sub;
                        time_total_reg <= tt_sub;
                    end
                    else if (km_count_reg + 1'b1 >= KW'(WINDOW))
                    begin
                        full_reg     <= 1'b1;
                        km_count_reg <= KW'(WINDOW);
                    end
                    else
                    begin
                        km_count_reg <= km_count_reg + 1'b1;
                    end
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    fuel_total_reg <= ftsum[56] ? MAX56 : ftsum[55:0];
                    time_total_reg <= ttsum[48] ? MAX48 : ttsum[47:0];
                    head_reg       <= head_inc;
                    dist_reg       <= dist_reg - KM_UNITS;
                    fuel_acc_reg   <= '0;
                    time_acc_reg   <= '0;
                    closed_reg     <= 1'b1;
                    state_reg      <= S_DIV1;
                end
                S_DIV1:
                begin
                    state_reg <= S_WAIT1;
                end
                S_WAIT1:
                begin
                    if (!div_busy)
                    begin
                        cons_reg  <= (div_q > 64'd65535) ? 16'hFFFF : div_q[15:0];
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    state_reg <= S_WAIT2;
                end
                S_WAIT2:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_reg.avg_consumption_centi <= (km_count_reg == '0) ? '0
                                                                              : cons_reg;
                        out_reg.avg_speed_centi <= (time_total_reg < ONE_SECOND_US) ? '0
                            : ((div_q > 64'd65535) ? 16'hFFFF : div_q[15:0]);
                        out_reg.window_km <= 8'(km_count_reg);
                        out_reg.km_closed <= closed_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TWA_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, km_count_reg <= KW'(WINDOW))
    `TWA_ASSERT_IMPL(a_full_cnt, clk, rst_n, full_reg, km_count_reg == KW'(WINDOW))
    `TWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !result.ready, out_valid_reg)
    `TWA_ASSERT_NEXT(a_out_set, clk, rst_n, state_reg == S_OUT, out_valid_reg)
endmodule

/* hw/rtl/twa_ram.sv */
// ----------------------------------------------------------------------------
// twa_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
module twa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hw/rtl/twa_div.sv */
// ----------------------------------------------------------------------------
// twa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module twa_div
    import twa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);
    localparam int unsigned CW = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
